[hdl/rotation_matrix_to_quaternion_macros.svh]
// assertion macros for the matrix to quaternion block
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
// property that holds from one edge to the next
`define RMQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
// property that holds at the same edge
`define RMQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`endif

[hdl/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// rmq_pkg
// types, constants and helpers for the matrix to quaternion block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rmq_pkg;
   localparam int DW = 16;
   localparam int FB = 14;
   localparam int AW = DW + 3;                // root argument width
   localparam int RAW = AW + FB;              // shifted argument width
   localparam int RW = (RAW + 1) / 2;         // root width
   localparam int SW = DW + 1;                // component sum width
   localparam int NW = SW + FB;               // dividend width
   localparam int QW = NW;                    // quotient width
   localparam int DENW = RW + 1;              // divisor width
   localparam int QDEPTH = 4;
   localparam int QPTRW = 2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_ARG = 2'd1;
   localparam logic [1:0] ST_SAT = 2'd2;

   localparam logic signed [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};

   typedef struct packed {
      logic signed [DW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0] qx, qy, qz, qw;
      logic [1:0] status;
   } rsp_type;

   // classified item: root argument, three signed sums, placement
   typedef struct packed {
      logic bad;
      logic [AW-1:0] arg;
      logic signed [SW-1:0] s0, s1, s2;   // dividends for slots j, k, w or x, y, z
      logic [1:0] main_idx;               // slot of the root component 0..3
   } job_type;

   function automatic logic signed [DW-1:0] clamp(input logic signed [QW:0] v,
                                                  output logic sat);
      sat = 1'b0;
      if (v > (QW+1)'(signed'(Q_MAX))) begin
         sat = 1'b1;
         return Q_MAX;
      end
      if (v < (QW+1)'(signed'(Q_MIN))) begin
         sat = 1'b1;
         return Q_MIN;
      end
      return v[DW-1:0];
   endfunction
endpackage

[hdl/rotation_matrix_to_quaternion.sv]
// path from req to rsp: input queue, root and divide stages (one bit each), result register, output queue
// throughput: one matrix per cycle while rsp side pops
// pipeline stalls as a whole while a result waits on the full 4-entry output queue
// reset: synchronous, active high; clears queues and valid bits, no clearing pass
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// converts a Q2.14 rotation matrix to a Q2.14 quaternion
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion import rmq_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  req_type req_data,
   output logic empty,
   input  logic pop,
   output rsp_type rsp_data
);
   job_type fjob, qjob;
   logic q_empty, q_rd, b_ready;
   rmq_front u_front (.in_data(req_data), .job(fjob));
   rmq_queue u_queue (
      .clock(clock), .reset(reset),
      .wr_en(push && !full), .wr_data(fjob), .full(full),
      .rd_en(q_rd), .empty(q_empty), .rd_data(qjob)
   );
   assign q_rd = !q_empty && b_ready;
   rmq_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(!q_empty), .in_job(qjob), .in_ready(b_ready),
      .out_empty(empty), .out_pop(pop), .out_data(rsp_data)
   );
endmodule

[hdl/rmq_front.sv]
// ----------------------------------------------------------------------------
// rmq_front
// trace test, diagonal pick and component sums
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rmq_front import rmq_pkg::*; (
   input  req_type in_data,
   output job_type job
);
   logic signed [DW+1:0] trace;
   logic signed [AW-1:0] a;
   logic signed [DW-1:0] d0, d1, d2;
   always_comb begin
      d0 = in_data.m00;
      d1 = in_data.m11;
      d2 = in_data.m22;
      trace = (DW+2)'(d0) + (DW+2)'(d1) + (DW+2)'(d2);
      job.s0 = '0;
      job.s1 = '0;
      job.s2 = '0;
      a = '0;
      if (!trace[DW+1]) begin
         a = AW'(trace) + AW'(1 << FB);
         job.main_idx = 2'd3;
         job.s0 = SW'(in_data.m21) - SW'(in_data.m12);
         job.s1 = SW'(in_data.m02) - SW'(in_data.m20);
         job.s2 = SW'(in_data.m10) - SW'(in_data.m01);
      end else if (d2 > ((d1 > d0) ? d1 : d0)) begin
         job.main_idx = 2'd2;
         a = AW'(d2) - AW'(d0) - AW'(d1) + AW'(1 << FB);
         job.s0 = SW'(in_data.m20) + SW'(in_data.m02);   // x
         job.s1 = SW'(in_data.m12) + SW'(in_data.m21);   // y
         job.s2 = SW'(in_data.m10) - SW'(in_data.m01);   // w
      end else if (d1 > d0) begin
         job.main_idx = 2'd1;
         a = AW'(d1) - AW'(d2) - AW'(d0) + AW'(1 << FB);
         job.s0 = SW'(in_data.m12) + SW'(in_data.m21);   // z
         job.s1 = SW'(in_data.m01) + SW'(in_data.m10);   // x
         job.s2 = SW'(in_data.m02) - SW'(in_data.m20);   // w
      end else begin
         job.main_idx = 2'd0;
         a = AW'(d0) - AW'(d1) - AW'(d2) + AW'(1 << FB);
         job.s0 = SW'(in_data.m01) + SW'(in_data.m10);   // y
         job.s1 = SW'(in_data.m20) + SW'(in_data.m02);   // z
         job.s2 = SW'(in_data.m21) - SW'(in_data.m12);   // w
      end
      job.bad = a[AW-1] || (a == '0);
      job.arg = job.bad ? '0 : a;
   end
endmodule

[hdl/rmq_queue.sv]
// ----------------------------------------------------------------------------
// rmq_queue
// short queue between classifier and arithmetic pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rmq_queue import rmq_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic wr_en,
   input  job_type wr_data,
   output logic full,
   input  logic rd_en,
   output logic empty,
   output job_type rd_data
);
   `include "rotation_matrix_to_quaternion_macros.svh"
   job_type mem_ff [QDEPTH];
   logic [QPTRW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QPTRW:0] cnt_ff, cnt_in;
   always_comb begin
      wp_in = wp_ff + QPTRW'(wr_en);
      rp_in = rp_ff + QPTRW'(rd_en);
      cnt_in = cnt_ff + (QPTRW+1)'(wr_en) - (QPTRW+1)'(rd_en);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end
   assign rd_data = mem_ff[rp_ff];
   assign full = cnt_ff == (QPTRW+1)'(QDEPTH);
   assign empty = cnt_ff == '0;
   `RMQ_ASSERT_NOW(a_no_overrun, clock, reset, full, !wr_en)
   `RMQ_ASSERT_NOW(a_no_underrun, clock, reset, empty, !rd_en)
   `RMQ_ASSERT_NEXT(a_count, clock, reset, wr_en && !rd_en, cnt_ff == $past(cnt_ff) + 1'b1)
endmodule

[hdl/rmq_back.sv]
// ----------------------------------------------------------------------------
// rmq_back
// pipelined root, dividers, clamp and output queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rmq_back import rmq_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  job_type in_job,
   output logic in_ready,
   output logic out_empty,
   input  logic out_pop,
   output rsp_type out_data
);
   `include "rotation_matrix_to_quaternion_macros.svh"
   localparam int RS = RW;             // root stages, one bit each
   localparam int DS = QW;             // divide stages, one bit each
   localparam int OD = 4;
   localparam int OPW = 2;

   // root pipeline
   logic [RAW-1:0] rrad_ff [RS+1];
   logic [RW-1:0] rroot_ff [RS+1];
   logic [RW+1:0] rrem_ff [RS+1];
   job_type rjob_ff [RS+1];
   logic rv_ff [RS+1];
   always_comb begin
      rrad_ff[0] = {in_job.arg, {FB{1'b0}}};
      rroot_ff[0] = '0;
      rrem_ff[0] = '0;
      rjob_ff[0] = in_job;
      rv_ff[0] = in_valid && in_ready;
   end
   for (genvar s = 0; s < RS; s++) begin : g_root
      logic [RW+1:0] rem_w, trial;
      logic [2*RW-1:0] pad;
      always_comb begin
         pad = (2*RW)'(rrad_ff[s]) << (2 * s);
         rem_w = {rrem_ff[s][RW-1:0], pad[2*RW-1 -: 2]};
         trial = {rroot_ff[s], 2'b01};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            rv_ff[s+1] <= 1'b0;
         end else if (in_ready) begin
            rv_ff[s+1] <= rv_ff[s];
         end
         if (in_ready) begin
            rrad_ff[s+1] <= rrad_ff[s];
            rjob_ff[s+1] <= rjob_ff[s];
            if (rem_w >= trial) begin
               rrem_ff[s+1] <= rem_w - trial;
               rroot_ff[s+1] <= {rroot_ff[s][RW-2:0], 1'b1};
            end else begin
               rrem_ff[s+1] <= rem_w;
               rroot_ff[s+1] <= {rroot_ff[s][RW-2:0], 1'b0};
            end
         end
      end
   end

   // three parallel restoring dividers
   logic [DENW-1:0] dden_ff [DS+1];
   logic [NW-1:0] dnum_ff [DS+1][3];
   logic [QW-1:0] dq_ff [DS+1][3];
   logic [DENW-1:0] drem_ff [DS+1][3];
   logic dneg_ff [DS+1][3];
   logic [RW-1:0] droot_ff [DS+1];
   logic dbad_ff [DS+1];
   logic [1:0] dmain_ff [DS+1];
   logic dv_ff [DS+1];
   always_comb begin
      job_type j;
      logic signed [SW-1:0] sv [3];
      j = rjob_ff[RS];
      sv[0] = j.s0;
      sv[1] = j.s1;
      sv[2] = j.s2;
      dden_ff[0] = {rroot_ff[RS], 1'b0};
      droot_ff[0] = rroot_ff[RS];
      dbad_ff[0] = j.bad || (rroot_ff[RS] == '0);
      dmain_ff[0] = j.main_idx;
      dv_ff[0] = rv_ff[RS];
      for (int c = 0; c < 3; c++) begin
         dneg_ff[0][c] = sv[c][SW-1];
         dnum_ff[0][c] = {(sv[c][SW-1] ? SW'(-sv[c]) : SW'(sv[c])), {FB{1'b0}}};
         dq_ff[0][c] = '0;
         drem_ff[0][c] = '0;
      end
   end
   for (genvar s = 0; s < DS; s++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[s+1] <= 1'b0;
         end else if (in_ready) begin
            dv_ff[s+1] <= dv_ff[s];
         end
      end
      for (genvar c = 0; c < 3; c++) begin : g_lane
         logic [DENW:0] rw;
         assign rw = {drem_ff[s][c], dnum_ff[s][c][NW-1-s]};
         always_ff @(posedge clock) begin
            if (in_ready) begin
               dnum_ff[s+1][c] <= dnum_ff[s][c];
               dneg_ff[s+1][c] <= dneg_ff[s][c];
               if (rw >= {1'b0, dden_ff[s]}) begin
                  drem_ff[s+1][c] <= DENW'(rw - {1'b0, dden_ff[s]});
                  dq_ff[s+1][c] <= {dq_ff[s][c][QW-2:0], 1'b1};
               end else begin
                  drem_ff[s+1][c] <= DENW'(rw);
                  dq_ff[s+1][c] <= {dq_ff[s][c][QW-2:0], 1'b0};
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         if (in_ready) begin
            dden_ff[s+1] <= dden_ff[s];
            droot_ff[s+1] <= droot_ff[s];
            dbad_ff[s+1] <= dbad_ff[s];
            dmain_ff[s+1] <= dmain_ff[s];
         end
      end
   end

   // clamp and place
   rsp_type res_in, res_ff;
   logic res_v_ff;
   always_comb begin
      logic signed [DW-1:0] c [3];
      logic signed [DW-1:0] mc;
      logic sat, st;
      logic [RW-2:0] half;
      sat = 1'b0;
      for (int k = 0; k < 3; k++) begin
         c[k] = clamp(dneg_ff[DS][k] ? -$signed({1'b0, dq_ff[DS][k]})
                                     : $signed({1'b0, dq_ff[DS][k]}), st);
         sat = sat | st;
      end
      half = droot_ff[DS][RW-1:1];
      mc = clamp($signed((QW+1)'(half)), st);
      sat = sat | st;
      res_in = '0;
      unique case (dmain_ff[DS])
         2'd0: begin
            res_in.qx = mc; res_in.qy = c[0]; res_in.qz = c[1]; res_in.qw = c[2];
         end
         2'd1: begin
            res_in.qy = mc; res_in.qz = c[0]; res_in.qx = c[1]; res_in.qw = c[2];
         end
         2'd2: begin
            res_in.qz = mc; res_in.qx = c[0]; res_in.qy = c[1]; res_in.qw = c[2];
         end
         default: begin
            res_in.qw = mc; res_in.qx = c[0]; res_in.qy = c[1]; res_in.qz = c[2];
         end
      endcase
      res_in.status = sat ? ST_SAT : ST_OK;
      if (dbad_ff[DS]) begin
         res_in = '0;
         res_in.status = ST_ARG;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         res_v_ff <= 1'b0;
      end else if (in_ready) begin
         res_v_ff <= dv_ff[DS];
      end
      if (in_ready) begin
         res_ff <= res_in;
      end
   end

   // output queue; the pipeline holds while a result waits on a full queue
   rsp_type oq_ff [OD];
   logic [OPW-1:0] owp_ff, orp_ff;
   logic [OPW:0] ocnt_ff, ocnt_in;
   logic push_o, pop_o;
   assign push_o = in_ready && res_v_ff;
   assign pop_o = out_pop && !out_empty;
   assign in_ready = !res_v_ff || (32'(ocnt_ff) < OD);
   always_comb begin
      ocnt_in = ocnt_ff + (OPW+1)'(push_o) - (OPW+1)'(pop_o);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         owp_ff <= '0;
         orp_ff <= '0;
         ocnt_ff <= '0;
      end else begin
         owp_ff <= owp_ff + OPW'(push_o);
         orp_ff <= orp_ff + OPW'(pop_o);
         ocnt_ff <= ocnt_in;
      end
   end
   always_ff @(posedge clock) begin
      if (push_o) begin
         oq_ff[owp_ff] <= res_ff;
      end
   end
   assign out_empty = ocnt_ff == '0;
   assign out_data = oq_ff[orp_ff];

   `RMQ_ASSERT_NOW(a_out_fits, clock, reset, 1'b1, 32'(ocnt_ff) <= OD)
   `RMQ_ASSERT_NOW(a_no_overflow, clock, reset, push_o, 32'(ocnt_ff) < OD || pop_o)
   `RMQ_ASSERT_NEXT(a_pop_moves, clock, reset, pop_o && !push_o, ocnt_ff == $past(ocnt_ff) - 1'b1)
endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// checks the matrix to quaternion block: a table of directed matrices, then
// random rotations and raw matrices, each result compared with a predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
   import rmq_pkg::*;

   localparam int N_RANDOM = 550;
   localparam int N_DIR = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty;
   req_type req_data = '0;
   rsp_type rsp_data;

   rsp_type quat_q[$];
   int errors = 0;
   int n_sent = 0;
   int n_got = 0;
   int n_status[4] = '{0, 0, 0, 0};
   bit calm = 1'b0;

   rotation_matrix_to_quaternion u_dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   function automatic logic [63:0] isqrt(input logic [63:0] v);
      logic [63:0] root, rem, trial;
      root = 0;
      rem = 0;
      for (int p = 62; p >= 0; p -= 2) begin
         rem = (rem << 2) | ((v >> p) & 64'd3);
         trial = (root << 2) | 64'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 64'd1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic longint sat16(input longint v, inout bit s);
      if (v > 32767) begin
         s = 1'b1;
         return 32767;
      end
      if (v < -32768) begin
         s = 1'b1;
         return -32768;
      end
      return v;
   endfunction

   function automatic longint qdiv(input longint sum, input longint den);
      longint mag;
      mag = (sum < 0) ? -sum : sum;
      mag = (mag <<< FB) / den;
      return (sum < 0) ? -mag : mag;
   endfunction

   function automatic rsp_type to_quaternion(input req_type d);
      longint m[3][3];
      longint q[4];
      longint one, tr, arg, r, den;
      int i, j, k;
      bit s;
      rsp_type o;
      m[0][0] = d.m00; m[0][1] = d.m01; m[0][2] = d.m02;
      m[1][0] = d.m10; m[1][1] = d.m11; m[1][2] = d.m12;
      m[2][0] = d.m20; m[2][1] = d.m21; m[2][2] = d.m22;
      q = '{0, 0, 0, 0};
      s = 1'b0;
      one = 64'sd1 <<< FB;
      o.status = ST_OK;
      tr = m[0][0] + m[1][1] + m[2][2];
      if (tr < 0) begin
         i = 0;
         if (m[1][1] > m[0][0]) i = 1;
         if (m[2][2] > m[i][i]) i = 2;
         j = (i + 1) % 3;
         k = (i + 2) % 3;
         arg = m[i][i] - m[j][j] - m[k][k] + one;
      end else begin
         i = 3; j = 0; k = 0;
         arg = tr + one;
      end
      r = (arg > 0) ? longint'(isqrt(64'(arg) << FB)) : 0;
      den = r * 2;
      if (den == 0) begin
         o.status = ST_ARG;
      end else if (i == 3) begin
         q[0] = sat16(qdiv(m[2][1] - m[1][2], den), s);
         q[1] = sat16(qdiv(m[0][2] - m[2][0], den), s);
         q[2] = sat16(qdiv(m[1][0] - m[0][1], den), s);
         q[3] = sat16(r >>> 1, s);
      end else begin
         q[i] = sat16(r >>> 1, s);
         q[j] = sat16(qdiv(m[i][j] + m[j][i], den), s);
         q[k] = sat16(qdiv(m[k][i] + m[i][k], den), s);
         q[3] = sat16(qdiv(m[k][j] - m[j][k], den), s);
      end
      if (o.status == ST_OK && s) o.status = ST_SAT;
      o.qx = q[0][15:0];
      o.qy = q[1][15:0];
      o.qz = q[2][15:0];
      o.qw = q[3][15:0];
      return o;
   endfunction

   function automatic req_type diag(input int a, input int b, input int c);
      req_type d;
      d = '0;
      d.m00 = a[15:0];
      d.m11 = b[15:0];
      d.m22 = c[15:0];
      return d;
   endfunction

   // random rotation built from a random unit quaternion
   function automatic req_type rand_rotation();
      real x, y, z, w, n;
      req_type d;
      x = $urandom_range(0, 2000) - 1000.0;
      y = $urandom_range(0, 2000) - 1000.0;
      z = $urandom_range(0, 2000) - 1000.0;
      w = $urandom_range(0, 2000) - 1000.0;
      n = $sqrt(x * x + y * y + z * z + w * w) + 1e-9;
      x = x / n; y = y / n; z = z / n; w = w / n;
      d.m00 = 16'($rtoi((1 - 2 * (y * y + z * z)) * 16383.0));
      d.m01 = 16'($rtoi(2 * (x * y - z * w) * 16383.0));
      d.m02 = 16'($rtoi(2 * (x * z + y * w) * 16383.0));
      d.m10 = 16'($rtoi(2 * (x * y + z * w) * 16383.0));
      d.m11 = 16'($rtoi((1 - 2 * (x * x + z * z)) * 16383.0));
      d.m12 = 16'($rtoi(2 * (y * z - x * w) * 16383.0));
      d.m20 = 16'($rtoi(2 * (x * z - y * w) * 16383.0));
      d.m21 = 16'($rtoi(2 * (y * z + x * w) * 16383.0));
      d.m22 = 16'($rtoi((1 - 2 * (x * x + y * y)) * 16383.0));
      return d;
   endfunction

   function automatic req_type rand_matrix();
      req_type d;
      d = req_type'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      if ($urandom_range(0, 3) == 0) begin
         d.m00 = 16'($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
         d.m12 = 16'($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
      end
      return d;
   endfunction

   task automatic send(input req_type d);
      while (!calm && $urandom_range(0, 99) < 21) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (full) @(posedge clock);
      quat_q.push_back(to_quaternion(d));
      n_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) begin
            if (quat_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected transfer %p", rsp_data);
            end else begin
               rsp_type e;
               e = quat_q.pop_front();
               if (rsp_data !== e) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch qx %0d/%0d qy %0d/%0d qz %0d/%0d qw %0d/%0d st %0d/%0d",
                        e.qx, rsp_data.qx, e.qy, rsp_data.qy, e.qz, rsp_data.qz,
                        e.qw, rsp_data.qw, e.status, rsp_data.status);
               end
               n_status[e.status]++;
               n_got++;
            end
         end
         pop <= calm || ($urandom_range(0, 99) >= 21);
      end
   end

   initial begin
      #4000000;
      $display("rotation_matrix_to_quaternion verification failed");
      $finish;
   end

   initial begin
      req_type dir_tab[N_DIR];
      rsp_type dir_exp[N_DIR];
      bit dir_typed[N_DIR];
      req_type d;
      int w;
      dir_typed = '{default: 1'b0};
      // identity
      dir_tab[0] = diag(16384, 16384, 16384);
      dir_exp[0] = '{qx: 0, qy: 0, qz: 0, qw: 16'sd16384, status: ST_OK};
      dir_typed[0] = 1'b1;
      // zero matrix: trace zero, root of one
      dir_tab[1] = '0;
      dir_exp[1] = '{qx: 0, qy: 0, qz: 0, qw: 16'sd8192, status: ST_OK};
      dir_typed[1] = 1'b1;
      // negative trace, equal diagonal
      dir_tab[2] = diag(-16384, -16384, -16384);
      // rotations of pi about each axis
      dir_tab[3] = diag(16384, -16384, -16384);
      dir_tab[4] = diag(-16384, 16384, -16384);
      dir_tab[5] = diag(-16384, -16384, 16384);
      // ties on the diagonal
      dir_tab[6] = diag(-8192, -8192, -8192);
      dir_tab[7] = diag(-16384, 0, 0);
      dir_tab[8] = diag(0, -16384, 0);
      // extremes
      dir_tab[9] = diag(32767, 32767, 32767);
      dir_tab[10] = diag(-32768, -32768, -32768);
      dir_tab[11] = req_type'({9{16'h7fff}});
      dir_tab[12] = req_type'({9{16'h8000}});
      dir_tab[13] = req_type'({16'h0000, 16'h8000, 16'h7fff, 16'h7fff, 16'h0000,
                              16'h8000, 16'h8000, 16'h7fff, 16'h0000});
      dir_tab[14] = diag(-32768, 32767, -32768);
      dir_tab[15] = req_type'({16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
                              16'h7fff, 16'h7fff, 16'h8000, 16'h8000});
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int n = 0; n < N_DIR; n++) begin
         if (dir_typed[n] && to_quaternion(dir_tab[n]) !== dir_exp[n]) begin
            errors++;
            $display("predictor disagrees on table row %0d", n);
         end
         send(dir_tab[n]);
      end
      for (int n = 0; n < N_RANDOM; n++) begin
         calm = (n >= 200 && n < 300);
         w = $urandom_range(0, 9);
         if (w < 7) d = rand_rotation();
         else d = rand_matrix();
         send(d);
      end
      push <= 1'b0;
      calm = 1'b0;
      w = 0;
      while (quat_q.size() != 0 && w < 20000) begin
         @(posedge clock);
         w++;
      end
      repeat (100) @(posedge clock);
      $display("%0d matrices sent, %0d quaternions checked", n_sent, n_got);
      $display("status ok %0d, bad root %0d, saturated %0d",
         n_status[ST_OK], n_status[ST_ARG], n_status[ST_SAT]);
      if (errors == 0 && quat_q.size() == 0) begin
         $display("rotation_matrix_to_quaternion verification clean");
      end else begin
         $display("rotation_matrix_to_quaternion verification failed");
      end
      $finish;
   end
endmodule
